>>> src/pf_pkg.sv
package pf_pkg;

  // wheel steps from 7 through the mod-30 candidates
  function automatic logic [2:0] wheel_step(input logic [2:0] pos);
    logic [2:0] s;
    unique case (pos)
      3'd0: s = 3'd4;
      3'd1: s = 3'd2;
      3'd2: s = 3'd4;
      3'd3: s = 3'd2;
      3'd4: s = 3'd4;
      3'd5: s = 3'd6;
      3'd6: s = 3'd2;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] small_prime(input logic [1:0] idx);
    logic [2:0] p;
    unique case (idx)
      2'd0: p = 3'd2;
      2'd1: p = 3'd3;
      2'd2: p = 3'd5;
      default: p = 3'd7;
    endcase
    return p;
  endfunction

endpackage

>>> src/pf_front.sv
module pf_front #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] value_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] value_o,
  output logic         trivial_o
);

  logic [W-1:0] val_q [2];
  logic [1:0]   triv_q;
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign value_o   = val_q[rd_q];
  assign trivial_o = triv_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      val_q[wr_q] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
      triv_q <= 2'b00;
    end else begin
      if (do_push) begin
        // zero and one have no prime factors
        triv_q[wr_q] <= (value_i[W-1:1] == '0);
        wr_q         <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> src/pf_back.sv
module pf_back
  import pf_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_empty_i,
  input  logic [W-1:0] in_value_i,
  input  logic         in_trivial_i,
  output logic         in_pop_o,
  input  logic         out_full_i,
  output logic         out_push_o,
  output logic [W-1:0] out_factor_o,
  output logic         out_last_o,
  output logic         out_nof_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_TRIV   = 3'd5;
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic [2:0]   st_q, st_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] div_q, div_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W:0]   acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]   sp_q, sp_d;
  logic         wheel_q, wheel_d;
  logic [2:0]   pos_q, pos_d;
  logic [W-1:0] pend_q, pend_d;
  logic         pend_v_q, pend_v_d;
  logic [W:0]   shifted;

  assign shifted = {acc_q[W-1:0], quo_q[W-1]};

  always_comb begin
    st_d = st_q; rem_d = rem_q; div_d = div_q; quo_d = quo_q; acc_d = acc_q;
    cnt_d = cnt_q; sp_d = sp_q; wheel_d = wheel_q; pos_d = pos_q;
    pend_d = pend_q; pend_v_d = pend_v_q;
    in_pop_o = 1'b0; out_push_o = 1'b0;
    out_factor_o = pend_q; out_last_o = 1'b0; out_nof_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          rem_d    = in_value_i;
          div_d    = W'(2);
          sp_d     = 2'd0;
          wheel_d  = 1'b0;
          pos_d    = 3'd0;
          pend_v_d = 1'b0;
          st_d     = in_trivial_i ? S_TRIV : S_START;
        end
      end
      S_START: begin
        acc_d = '0;
        quo_d = rem_q;
        cnt_d = CW'(W - 1);
        st_d  = S_DIV;
      end
      S_DIV: begin
        // one restoring step per cycle
        if (shifted >= {1'b0, div_q}) begin
          acc_d = shifted - {1'b0, div_q};
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          acc_d = shifted;
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) st_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (div_q > quo_q) begin
          st_d = S_FIN;
        end else if (acc_q == '0) begin
          if (!(pend_v_q && out_full_i)) begin
            out_push_o = pend_v_q;
            pend_d     = div_q;
            pend_v_d   = 1'b1;
            rem_d      = quo_q;
            st_d       = S_START;
          end
        end else begin
          if (!wheel_q) begin
            if (sp_q == 2'd3) begin
              wheel_d = 1'b1;
              div_d   = W'(11);
              pos_d   = 3'd1;
            end else begin
              sp_d  = sp_q + 1'b1;
              div_d = W'(small_prime(sp_q + 1'b1));
            end
          end else begin
            div_d = div_q + W'(wheel_step(pos_q));
            pos_d = pos_q + 1'b1;
          end
          st_d = S_START;
        end
      end
      S_FIN: begin
        if (pend_v_q) begin
          out_last_o = (rem_q[W-1:1] == '0);
          if (!out_full_i) begin
            out_push_o = 1'b1;
            pend_v_d   = 1'b0;
            if (rem_q[W-1:1] == '0) st_d = S_IDLE;
          end
        end else if (rem_q[W-1:1] != '0) begin
          out_factor_o = rem_q;
          out_last_o   = 1'b1;
          if (!out_full_i) begin
            out_push_o = 1'b1;
            st_d       = S_IDLE;
          end
        end else begin
          st_d = S_IDLE;
        end
      end
      S_TRIV: begin
        out_factor_o = '0;
        out_last_o   = 1'b1;
        out_nof_o    = 1'b1;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    sp_q   <= sp_d;
    pos_q  <= pos_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      wheel_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      wheel_q  <= wheel_d;
      pend_v_q <= pend_v_d;
    end
  end

endmodule

>>> src/pf_outq.sv
module pf_outq #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] factor_i,
  input  logic         last_i,
  input  logic         nof_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] factor_o,
  output logic         last_o,
  output logic         nof_o
);

  logic [W+1:0] word_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign {factor_o, last_o, nof_o} = word_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      word_q[wr_q] <= {factor_i, last_i, nof_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> src/prime_factorizer.sv
// channel  | ports                                   | handshake
// input    | value_i                                 | push, full
// result   | factor_o, last_o, no_factor_o           | pop, empty
//
// each trial division runs on a bit-serial restoring divider; an item needs one
// division per trial divisor plus one per factor found.
// two-word queues on both sides let input and result sides stall on their own.
// reset is asynchronous and active low and empties both queues.
module prime_factorizer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   pop,
  output logic                   empty,
  output logic [VALUE_WIDTH-1:0] factor_o,
  output logic                   last_o,
  output logic                   no_factor_o
);

  logic                   f_empty, f_pop, f_triv;
  logic [VALUE_WIDTH-1:0] f_value;
  logic                   o_full, o_push, o_last, o_nof;
  logic [VALUE_WIDTH-1:0] o_factor;

  pf_front #(.W(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .value_i,
    .pop_i(f_pop), .empty_o(f_empty), .value_o(f_value), .trivial_o(f_triv)
  );

  pf_back #(.W(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .in_empty_i(f_empty), .in_value_i(f_value), .in_trivial_i(f_triv),
    .in_pop_o(f_pop),
    .out_full_i(o_full), .out_push_o(o_push), .out_factor_o(o_factor),
    .out_last_o(o_last), .out_nof_o(o_nof)
  );

  pf_outq #(.W(VALUE_WIDTH)) u_outq (
    .clk_i, .rst_ni,
    .push_i(o_push), .full_o(o_full),
    .factor_i(o_factor), .last_i(o_last), .nof_i(o_nof),
    .pop_i(pop), .empty_o(empty),
    .factor_o, .last_o, .nof_o(no_factor_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_push |-> !o_full) else $error("result written into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_pop |-> !f_empty) else $error("item taken from empty queue");

  a_nof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && no_factor_o) |-> (factor_o == '0 && last_o))
    else $error("no-factor word malformed");

endmodule

>>> test/prime_factorizer_tb.sv
module prime_factorizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = 32;
  localparam int unsigned STALL_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [VW-1:0] factor;
    logic          last;
    logic          no_factor;
  } factor_word_t;

  localparam int unsigned FIRST_PRIMES [4] = '{2, 3, 5, 7};
  localparam int unsigned WHEEL_GAPS [8] = '{4, 2, 4, 2, 4, 6, 2, 6};
  localparam int unsigned SMOOTH_PRIMES [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          push = 1'b0;
  logic          full;
  logic [VW-1:0] value_i = '0;
  logic          pop = 1'b0;
  logic          empty;
  logic [VW-1:0] factor_o;
  logic          last_o;
  logic          no_factor_o;

  factor_word_t factor_q [$];
  int unsigned  error_cnt = 0;
  bit           tx_idle = 1'b0;
  bit           rx_idle = 1'b0;
  int unsigned  rx_hold = 0;

  prime_factorizer #(.VALUE_WIDTH(VW)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .pop         (pop),
    .empty       (empty),
    .factor_o    (factor_o),
    .last_o      (last_o),
    .no_factor_o (no_factor_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void append_word(input factor_word_t w);
    factor_q = {factor_q, w};
  endfunction

  // trial division over 2, 3, 5, 7 and then the mod-30 wheel
  function automatic void predict_factors(input logic [VW-1:0] v);
    longint unsigned rem;
    longint unsigned d;
    int unsigned     si;
    int unsigned     pos;
    factor_word_t    w;
    rem = v;
    if (rem < 2) begin
      w = '{factor: '0, last: 1'b1, no_factor: 1'b1};
      append_word(w);
      return;
    end
    si = 0;
    pos = 0;
    d = FIRST_PRIMES[0];
    while (d <= rem / d) begin
      while (rem % d == 0 && rem > 1) begin
        rem = rem / d;
        w = '{factor: d[VW-1:0], last: 1'b0, no_factor: 1'b0};
        append_word(w);
      end
      if (si < 3) begin
        si++;
        d = FIRST_PRIMES[si];
      end else begin
        d += WHEEL_GAPS[pos];
        pos = (pos + 1) % 8;
      end
    end
    if (rem > 1) begin
      w = '{factor: rem[VW-1:0], last: 1'b0, no_factor: 1'b0};
      append_word(w);
    end
    factor_q[factor_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_value(input logic [VW-1:0] v);
    int unsigned gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (full);
    predict_factors(v);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiving side: compare each popped word with the oldest prediction
  initial begin
    int unsigned  stall;
    factor_word_t exp_w;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (factor_q.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected word factor=%0d last=%0b no_factor=%0b",
                   $time, factor_o, last_o, no_factor_o);
        end else begin
          exp_w = factor_q.pop_front();
          if (factor_o !== exp_w.factor) begin
            error_cnt++;
            $display("%0t: factor expected %0d actual %0d", $time, exp_w.factor, factor_o);
          end
          if (last_o !== exp_w.last) begin
            error_cnt++;
            $display("%0t: last expected %0b actual %0b", $time, exp_w.last, last_o);
          end
          if (no_factor_o !== exp_w.no_factor) begin
            error_cnt++;
            $display("%0t: no_factor expected %0b actual %0b",
                     $time, exp_w.no_factor, no_factor_o);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        if (rx_idle && stall == 0 && $urandom_range(0, 7) == 0)
          stall = $urandom_range(1, 18);
        if (stall > 0) begin
          stall--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // no progress on either side for too long ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [VW-1:0] vals [$];
    vals = '{0, 1, 2, 3, 4, 5, 7, 11, 13, 25, 49, 121, 323, 30030, 65521, 999983,
             32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd4294967291 - 32'd0,
             32'h0001_0000};
    foreach (vals[i]) send_value(vals[i]);
    stop_sending();
  endtask

  // receiver holds off while small values keep coming, so the input backs up
  task automatic test_backpressure();
    rx_hold = 400;
    repeat (10) send_value(32'd4);
    send_value(32'd6);
    stop_sending();
  endtask

  function automatic logic [VW-1:0] random_value();
    longint unsigned prod;
    int unsigned     p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        prod = 1;
        forever begin
          p = SMOOTH_PRIMES[$urandom_range(0, 11)];
          if (prod * p > 64'hFFFF_FFFF || $urandom_range(0, 15) == 0) break;
          prod = prod * p;
        end
        return prod[VW-1:0];
      end
      4, 5, 6: return VW'($urandom_range(0, 65535)) << $urandom_range(0, 16);
      default: return VW'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_random(input int unsigned n_words, input bit with_idle);
    tx_idle = with_idle;
    rx_idle = with_idle;
    repeat (n_words) send_value(random_value());
    stop_sending();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(58, 1'b1);
    test_random(10, 1'b0);
    while (factor_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && factor_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
